// ===== rtl/core/button_debounce_autorepeat_top_defines.svh =====
// Assertion macros for the button debounce / auto-repeat block.
// Used by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Generic clocked property, disabled while reset is asserted
`define BDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Condition in a cycle implies a consequence in the next
`define BDA_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define BDA_ASSERT(lbl, prop, msg)
`define BDA_ASSERT_NEXT(lbl, cond, cons, msg)
`endif
`endif

// ===== rtl/core/bda_pkg.sv =====
// Package for the button debounce / auto-repeat block: defaults, codes, types.
// No dependencies; used by every other file of the block but the defines header.
`default_nettype none

package bda_pkg;

    // Parameter defaults
    localparam int NUM_BUTTONS_DEF = 4;
    localparam int TIME_BITS_DEF   = 32;

    // Fixed field widths
    localparam int MASK_W  = 4;   // buttons visible on the output side
    localparam int CODE_W  = 7;
    localparam int CFG_W   = 16;
    localparam int PROD_W  = CFG_W + CODE_W;  // period * count
    localparam int LIM_W   = PROD_W + 1;      // start + period * count
    localparam int APB_W   = 32;
    localparam int PADDR_W = 4;
    localparam int REGIDX_W = 2;

    // Configuration register indexes
    localparam logic [REGIDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_START    = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_PERIOD   = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] START_RST    = 16'd700;
    localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd200;

    // Repeat codes and saturation point
    localparam logic [CODE_W-1:0] CODE_NONE  = 7'd0;
    localparam logic [CODE_W-1:0] CODE_FRESH = 7'd1;
    localparam logic [CODE_W-1:0] REPEAT_MAX = 7'd100;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ms;
        logic [CFG_W-1:0] hold_start_ms;
        logic [CFG_W-1:0] repeat_period_ms;
    } t_cfg;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/bda_ifs.sv =====
// Valid/ready channel interfaces for poll transactions and result transactions.
// Depends on bda_pkg.
`default_nettype none

interface bda_in_if #(
    parameter int TIME_BITS = bda_pkg::TIME_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [bda_pkg::MASK_W-1:0]    btn_pins;
    logic [TIME_BITS-1:0]          now_ms;

    modport source (output valid, btn_pins, now_ms, input ready);
    modport sink   (input valid, btn_pins, now_ms, output ready);
endinterface

interface bda_out_if;
    logic                          valid;
    logic                          ready;
    logic [bda_pkg::MASK_W-1:0]    held_mask;
    logic [bda_pkg::MASK_W-1:0]    pressed_edge_mask;
    logic [bda_pkg::MASK_W-1:0]    released_edge_mask;
    logic [bda_pkg::CODE_W-1:0]    repeat_code_0;
    logic [bda_pkg::CODE_W-1:0]    repeat_code_1;
    logic [bda_pkg::CODE_W-1:0]    repeat_code_2;
    logic [bda_pkg::CODE_W-1:0]    repeat_code_3;

    modport source (output valid, held_mask, pressed_edge_mask, released_edge_mask,
                    repeat_code_0, repeat_code_1, repeat_code_2, repeat_code_3,
                    input ready);
    modport sink   (input valid, held_mask, pressed_edge_mask, released_edge_mask,
                    repeat_code_0, repeat_code_1, repeat_code_2, repeat_code_3,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bda_cfg.sv =====
// APB-style configuration registers: debounce time, repeat start, repeat period.
// Depends on bda_pkg.
`default_nettype none

module bda_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bda_pkg::PADDR_W-1:0]   paddr,
    input  logic [bda_pkg::APB_W-1:0]     pwdata,
    output logic [bda_pkg::APB_W-1:0]     prdata,
    output logic                          pready,
    output bda_pkg::t_cfg                 o_cfg
);

    bda_pkg::t_cfg                   r_cfg;
    logic [bda_pkg::REGIDX_W-1:0]    reg_idx;
    logic                            wr_en;

    assign reg_idx = paddr[bda_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes; out-of-range index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ms        <= bda_pkg::DEBOUNCE_RST;
            r_cfg.hold_start_ms    <= bda_pkg::START_RST;
            r_cfg.repeat_period_ms <= bda_pkg::PERIOD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                bda_pkg::REG_DEBOUNCE: begin
                    r_cfg.settle_ms <= pwdata[bda_pkg::CFG_W-1:0];
                end
                bda_pkg::REG_START: begin
                    r_cfg.hold_start_ms <= pwdata[bda_pkg::CFG_W-1:0];
                end
                bda_pkg::REG_PERIOD: begin
                    r_cfg.repeat_period_ms <= pwdata[bda_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (reg_idx)
            bda_pkg::REG_DEBOUNCE: prdata = bda_pkg::APB_W'(r_cfg.settle_ms);
            bda_pkg::REG_START:    prdata = bda_pkg::APB_W'(r_cfg.hold_start_ms);
            bda_pkg::REG_PERIOD:   prdata = bda_pkg::APB_W'(r_cfg.repeat_period_ms);
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/bda_state_mem.sv =====
// State memory holding every button's record in one row; registered read.
// A valid flag makes the row read as all zero (the reset state) until first written.
`default_nettype none

module bda_state_mem #(
    parameter int WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bda_pkg::t_mem_ctl     i_ctl,
    input  logic [WIDTH-1:0]      i_wr_data,
    output logic [WIDTH-1:0]      o_rd_data
);

    logic [WIDTH-1:0] r_mem [0:0];
    logic             r_valid;
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[0] <= i_wr_data;
        end
    end

    // Row valid flag, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.wr_en) begin
            r_valid <= 1'b1;
        end
    end

    // Registered read; an unwritten row reads as the reset state
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_valid ? r_mem[0] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/bda_lane.sv =====
// One button's update: debounce acceptance, edge detect and auto-repeat count.
// Depends on bda_pkg. Record layout {level, seen_time, change_time, count}.
`default_nettype none

module bda_lane #(
    parameter int TIME_BITS = bda_pkg::TIME_BITS_DEF,
    localparam int REC_W    = 2 * TIME_BITS + 1 + bda_pkg::CODE_W
) (
    input  logic                          i_pressed,
    input  logic [TIME_BITS-1:0]          i_now,
    input  bda_pkg::t_cfg                 i_cfg,
    input  logic [REC_W-1:0]              i_rec,
    output logic [REC_W-1:0]              o_rec,
    output logic                          o_held,
    output logic                          o_rise,
    output logic                          o_fall,
    output logic [bda_pkg::CODE_W-1:0]    o_code
);

    localparam int CMP_W = (TIME_BITS > bda_pkg::LIM_W) ? TIME_BITS : bda_pkg::LIM_W;
    localparam int CW    = bda_pkg::CODE_W;

    logic                     level;
    logic [TIME_BITS-1:0]     seen;
    logic [TIME_BITS-1:0]     chg;
    logic [CW-1:0]            cnt;

    logic [TIME_BITS-1:0]     age;
    logic                     differ;
    logic                     take;
    logic                     lvl_n;
    logic [TIME_BITS-1:0]     seen_n;
    logic [TIME_BITS-1:0]     chg_n;
    logic [CW-1:0]            cnt_base;
    logic [bda_pkg::PROD_W-1:0] prod;
    logic [bda_pkg::LIM_W-1:0]  limit;
    logic [TIME_BITS-1:0]     elapsed;
    logic                     over;
    logic [CW-1:0]            cnt_inc;
    logic [CW-1:0]            cnt_n;

    // Unpack record
    assign level = i_rec[REC_W-1];
    assign seen  = i_rec[REC_W-2 -: TIME_BITS];
    assign chg   = i_rec[CW +: TIME_BITS];
    assign cnt   = i_rec[CW-1:0];

    // Debounce: a change is taken once the last agreeing sample is old enough
    assign differ   = (i_pressed != level);
    assign age      = i_now - seen;
    assign take     = differ && (age >= TIME_BITS'(i_cfg.settle_ms));
    assign lvl_n    = take ? i_pressed : level;
    assign seen_n   = (take || !differ) ? i_now : seen;
    assign chg_n    = take ? i_now : chg;
    assign cnt_base = take ? '0 : cnt;

    // Repeat threshold; multiply uses the stored count, a fresh change uses zero
    assign prod    = bda_pkg::PROD_W'(i_cfg.repeat_period_ms) * bda_pkg::PROD_W'(cnt);
    assign limit   = take ? bda_pkg::LIM_W'(i_cfg.hold_start_ms)
                          : bda_pkg::LIM_W'(i_cfg.hold_start_ms) + bda_pkg::LIM_W'(prod);
    assign elapsed = take ? '0 : (i_now - chg);
    assign over    = lvl_n && (CMP_W'(elapsed) > CMP_W'(limit));

    // Saturating count step
    assign cnt_inc = (cnt_base >= bda_pkg::REPEAT_MAX) ? bda_pkg::REPEAT_MAX
                                                       : cnt_base + CW'(1);
    assign cnt_n   = over ? cnt_inc : cnt_base;

    // Outputs
    assign o_held = lvl_n;
    assign o_rise = lvl_n && !level;
    assign o_fall = !lvl_n && level;

    always_comb begin
        priority if (over) begin
            o_code = cnt_inc + CW'(1);
        end else if (o_rise) begin
            o_code = bda_pkg::CODE_FRESH;
        end else begin
            o_code = bda_pkg::CODE_NONE;
        end
    end

    assign o_rec = {lvl_n, seen_n, chg_n, cnt_n};

endmodule

`default_nettype wire

// ===== rtl/core/button_debounce_autorepeat_top.sv =====
// Top level of the button debounce / auto-repeat block: poll pipeline and output register.
// Depends on bda_pkg, bda_ifs, bda_cfg, bda_state_mem, bda_lane and the defines header.
//
//  Channel   Dir  Handshake                 Payload
//  i_in      in   valid/ready               btn_pins[3:0], now_ms[TIME_BITS-1:0]
//  o_out     out  valid/ready               held/pressed/released masks, repeat_code_0..3
//  APB       in   psel/penable/pwrite/pready  paddr[3:0], pwdata/prdata[31:0]
//
//  One poll per cycle sustained while o_out.ready stays high. The state row is read at the edge
//  that takes the poll, the lanes update from the update stage registers, and their result
//  loads the output register when the update stage fires.
//  A poll that follows directly takes the written-back state from a forwarding register.
//  Reset clears the state row's valid flag, so no clearing pass is needed.
//  With o_out.ready low the output register holds, the update stage fills, then
//  i_in.ready drops until the result transaction completes.
`default_nettype none
`include "button_debounce_autorepeat_top_defines.svh"

module button_debounce_autorepeat_top #(
    parameter int NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = bda_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bda_in_if.sink                        i_in,
    bda_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bda_pkg::PADDR_W-1:0]   paddr,
    input  logic [bda_pkg::APB_W-1:0]     pwdata,
    output logic [bda_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);

    localparam int REC_W = 2 * TIME_BITS + 1 + bda_pkg::CODE_W;
    localparam int ST_W  = NUM_BUTTONS * REC_W;
    localparam int MW    = bda_pkg::MASK_W;
    localparam int CW    = bda_pkg::CODE_W;

    bda_pkg::t_cfg            cfg;
    bda_pkg::t_mem_ctl        mem_ctl;

    logic                     in_ready;
    logic                     in_acc;
    logic                     s1_fire;

    logic                     r_s1_valid;
    logic                     r_s1_fwd;
    logic [MW-1:0]            r_s1_raw;
    logic [TIME_BITS-1:0]     r_s1_now;

    logic [ST_W-1:0]          mem_rd;
    logic [ST_W-1:0]          cur_state;
    logic [ST_W-1:0]          n_state;
    logic [ST_W-1:0]          r_wb;

    logic [NUM_BUTTONS-1:0]   lane_press;
    logic [NUM_BUTTONS-1:0]   lane_held;
    logic [NUM_BUTTONS-1:0]   lane_rise;
    logic [NUM_BUTTONS-1:0]   lane_fall;
    logic [CW-1:0]            lane_code [NUM_BUTTONS];

    logic [MW-1:0]            n_held;
    logic [MW-1:0]            n_rise;
    logic [MW-1:0]            n_fall;
    logic [CW-1:0]            n_code [MW];

    logic                     r_out_valid;
    logic [MW-1:0]            r_out_held;
    logic [MW-1:0]            r_out_rise;
    logic [MW-1:0]            r_out_fall;
    logic [CW-1:0]            r_out_code [MW];

    // Configuration registers
    bda_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: update stage advances when the output register is free or draining
    assign s1_fire    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_ready   = !r_s1_valid || s1_fire;
    assign in_acc     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Memory: read on accept, write back on update
    assign mem_ctl.rd_en = in_acc;
    assign mem_ctl.wr_en = s1_fire;

    bda_state_mem #(
        .WIDTH (ST_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_wr_data (n_state),
        .o_rd_data (mem_rd)
    );

    // Update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (in_acc) begin
                r_s1_fwd <= s1_fire;
            end
        end
    end

    // Update stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_raw <= i_in.btn_pins;
            r_s1_now <= i_in.now_ms;
        end
    end

    // Forwarding register: the row written in the cycle the current poll was read
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_wb <= n_state;
        end
    end

    assign cur_state = r_s1_fwd ? r_wb : mem_rd;

    // Per-button lanes; buttons past the raw field read as pressed
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        if (b < MW) begin : g_raw
            assign lane_press[b] = !r_s1_raw[b];
        end else begin : g_tied
            assign lane_press[b] = 1'b1;
        end

        bda_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_pressed (lane_press[b]),
            .i_now     (r_s1_now),
            .i_cfg     (cfg),
            .i_rec     (cur_state[b*REC_W +: REC_W]),
            .o_rec     (n_state[b*REC_W +: REC_W]),
            .o_held    (lane_held[b]),
            .o_rise    (lane_rise[b]),
            .o_fall    (lane_fall[b]),
            .o_code    (lane_code[b])
        );
    end

    // Output field mapping; absent buttons read as zero
    for (genvar b = 0; b < MW; b++) begin : g_map
        if (b < NUM_BUTTONS) begin : g_on
            assign n_held[b] = lane_held[b];
            assign n_rise[b] = lane_rise[b];
            assign n_fall[b] = lane_fall[b];
            assign n_code[b] = lane_code[b];
        end else begin : g_off
            assign n_held[b] = 1'b0;
            assign n_rise[b] = 1'b0;
            assign n_fall[b] = 1'b0;
            assign n_code[b] = bda_pkg::CODE_NONE;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_held <= n_held;
            r_out_rise <= n_rise;
            r_out_fall <= n_fall;
            r_out_code <= n_code;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.held_mask          = r_out_held;
    assign o_out.pressed_edge_mask  = r_out_rise;
    assign o_out.released_edge_mask = r_out_fall;
    assign o_out.repeat_code_0      = r_out_code[0];
    assign o_out.repeat_code_1      = r_out_code[1];
    assign o_out.repeat_code_2      = r_out_code[2];
    assign o_out.repeat_code_3      = r_out_code[3];

    // Checks
    `BDA_ASSERT(a_edges_vs_held, o_out.valid |-> (((o_out.pressed_edge_mask & ~o_out.held_mask) == '0) && ((o_out.released_edge_mask & o_out.held_mask) == '0)), "edge mask disagrees with held mask")
    `BDA_ASSERT(a_code_needs_held, (o_out.valid && (o_out.repeat_code_0 != bda_pkg::CODE_NONE)) |-> o_out.held_mask[0], "repeat code on a released button")
    `BDA_ASSERT(a_stall_blocks_input, (r_s1_valid && r_out_valid && !o_out.ready) |-> !i_in.ready, "poll taken while pipeline is full")
    `BDA_ASSERT_NEXT(a_update_lands, s1_fire, r_out_valid, "update stage result lost")

endmodule

`default_nettype wire
